// ----- design/rph_pkg.sv -----
// rph_pkg: shared types and constants for the rgb pixel hue extractor
// no dependencies; imported by every module of the block

package rph_pkg;

  // default widths
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int HUE_BITS_DEF    = 16;

  // fixed port widths
  localparam int IN_W  = 16;
  localparam int HUE_W = 16;

  // which channel holds the minimum, tested red first, then green
  typedef enum logic [1:0] {
    SEC_RED_MIN,
    SEC_GREEN_MIN,
    SEC_BLUE_MIN
  } rph_sector_t;

  // control that travels alongside each pipeline slot
  typedef struct packed {
    logic valid;
    logic achro;
  } rph_ctl_t;

endpackage

// ----- design/rgb_pixel_hue_extract.sv -----
// rgb_pixel_hue_extract: top level of the hexcone hue pipeline
// depends on rph_pkg, rph_prep and rph_div_stage
//
// usage
//   input: raise start with a pixel on in_red, in_green, in_blue (signed);
//   the transfer happens at a rising edge with start high and busy low
//   output: out_valid marks one cycle holding out_hue and out_achromatic;
//   the receiver takes the transfer in that cycle and cannot hold it off
//   path: every pixel passes the rph_prep register stages, then one divider stage per quotient bit
//   throughput: one pixel per clock, set by the fully pipelined divider with
//   one registered restoring step per quotient bit
//   hue is floor(num * 2^HUE_BITS / (6*d)) where d is max minus min of the
//   clamped channels; an equal max and min gives hue zero and achromatic set
//   reset: synchronous, active low; clears every valid bit in flight and
//   holds busy high for that cycle, after which busy stays low
//   no stall path: results leave on schedule regardless of the receiver

module rgb_pixel_hue_extract #(
  parameter int SAMPLE_BITS = rph_pkg::SAMPLE_BITS_DEF,
  parameter int HUE_BITS    = rph_pkg::HUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rph_pkg::IN_W-1:0]   in_red,
  input  logic signed [rph_pkg::IN_W-1:0]   in_green,
  input  logic signed [rph_pkg::IN_W-1:0]   in_blue,
  output logic                              out_valid,
  output logic        [rph_pkg::HUE_W-1:0]  out_hue,
  output logic                              out_achromatic
);
  import rph_pkg::*;

  // numerator and divisor width: 6*d stays below 2^(SAMPLE_BITS+2)
  localparam int NW = SAMPLE_BITS + 2;

  logic busy_r;
  logic in_xfer;

  // per-stage divider signals, index k feeds stage k
  rph_ctl_t      ctl [0:HUE_BITS];
  logic [NW-1:0] rem [0:HUE_BITS-1];
  logic [NW-1:0] den [0:HUE_BITS-1];
  logic [HUE_BITS-1:0] quo [0:HUE_BITS];

  // busy only covers the reset cycle; the pipeline never back-pressures
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy    = busy_r;
  assign in_xfer = start & ~busy_r;

  // front end: clamp, min/max, sector select, numerator and 6*d
  rph_prep #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_xfer),
    .red_i   (in_red),
    .green_i (in_green),
    .blue_i  (in_blue),
    .ctl_o   (ctl[0]),
    .num_o   (rem[0]),
    .den_o   (den[0])
  );

  assign quo[0] = '0;

  // divider: one quotient bit per stage, msb first
  for (genvar k = 0; k < HUE_BITS; k++) begin : g_div
    if (k < HUE_BITS - 1) begin : g_mid
      rph_div_stage #(
        .NW (NW),
        .QW (HUE_BITS)
      ) u_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl_i (ctl[k]),
        .rem_i (rem[k]),
        .den_i (den[k]),
        .quo_i (quo[k]),
        .ctl_o (ctl[k+1]),
        .rem_o (rem[k+1]),
        .den_o (den[k+1]),
        .quo_o (quo[k+1])
      );
    end else begin : g_last
      // last step: remainder and divisor are not needed downstream
      rph_div_stage #(
        .NW (NW),
        .QW (HUE_BITS)
      ) u_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl_i (ctl[k]),
        .rem_i (rem[k]),
        .den_i (den[k]),
        .quo_i (quo[k]),
        .ctl_o (ctl[k+1]),
        .rem_o (),
        .den_o (),
        .quo_o (quo[k+1])
      );
    end
  end

  // result transfer straight from the last divider register
  assign out_valid      = ctl[HUE_BITS].valid;
  assign out_achromatic = ctl[HUE_BITS].achro;
  assign out_hue        = HUE_W'(quo[HUE_BITS]);

endmodule

// ----- design/rph_prep.sv -----
// rph_prep: clamp, min/max, sector numerator and divisor set-up (four stages)
// depends on rph_pkg

module rph_prep #(
  parameter int SAMPLE_BITS = rph_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  valid_i,
  input  logic signed [rph_pkg::IN_W-1:0]       red_i,
  input  logic signed [rph_pkg::IN_W-1:0]       green_i,
  input  logic signed [rph_pkg::IN_W-1:0]       blue_i,
  output rph_pkg::rph_ctl_t                     ctl_o,
  output logic        [SAMPLE_BITS+1:0]         num_o,
  output logic        [SAMPLE_BITS+1:0]         den_o
);
  import rph_pkg::*;

  localparam int CW = SAMPLE_BITS - 1;
  localparam int NW = SAMPLE_BITS + 2;

  function automatic logic [CW-1:0] clamp_ch(input logic signed [IN_W-1:0] raw_in);
    logic signed [SAMPLE_BITS-1:0] raw;
    raw = SAMPLE_BITS'(raw_in);
    clamp_ch = raw[SAMPLE_BITS-1] ? '0 : raw[CW-1:0];
  endfunction

  // stage 1: clamped channels
  logic          v1_r;
  logic [CW-1:0] r1_r, g1_r, b1_r;

  // stage 2: spread and sector operands
  logic          v2_r;
  rph_sector_t   sec2_r;
  logic [CW-1:0] d2_r, p2_r, q2_r;

  // stage 3: numerator and six times spread
  logic          v3_r, a3_r;
  logic [NW-1:0] num3_r, six3_r;

  // stage 4: wrapped numerator and divisor
  rph_ctl_t      ctl4_r;
  logic [NW-1:0] num4_r, den4_r;

  logic [CW-1:0] mx2, mn2;
  rph_sector_t   sec2_nxt;
  logic [CW-1:0] p2_nxt, q2_nxt;
  logic [NW-1:0] d3_ext, kd3, num3_nxt, six3_nxt;

  always_comb begin
    mx2 = r1_r;
    mn2 = r1_r;
    if (g1_r > mx2) mx2 = g1_r;
    if (b1_r > mx2) mx2 = b1_r;
    if (g1_r < mn2) mn2 = g1_r;
    if (b1_r < mn2) mn2 = b1_r;
    if (r1_r == mn2) begin
      sec2_nxt = SEC_RED_MIN;
      p2_nxt   = b1_r;
      q2_nxt   = g1_r;
    end else if (g1_r == mn2) begin
      sec2_nxt = SEC_GREEN_MIN;
      p2_nxt   = r1_r;
      q2_nxt   = b1_r;
    end else begin
      sec2_nxt = SEC_BLUE_MIN;
      p2_nxt   = g1_r;
      q2_nxt   = r1_r;
    end
  end

  always_comb begin
    d3_ext = NW'(d2_r);
    unique case (sec2_r)
      SEC_RED_MIN:   kd3 = d3_ext + (d3_ext << 1);
      SEC_GREEN_MIN: kd3 = d3_ext + (d3_ext << 2);
      SEC_BLUE_MIN:  kd3 = d3_ext;
      default:       kd3 = d3_ext;
    endcase
    // result stays within 0 .. 6*d, so modular arithmetic is exact
    num3_nxt = kd3 + NW'(p2_r) - NW'(q2_r);
    six3_nxt = (d3_ext << 2) + (d3_ext << 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      ctl4_r <= '0;
    end else begin
      v1_r         <= valid_i;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      ctl4_r.valid <= v3_r;
      ctl4_r.achro <= a3_r;
    end
  end

  always_ff @(posedge clk) begin
    r1_r   <= clamp_ch(red_i);
    g1_r   <= clamp_ch(green_i);
    b1_r   <= clamp_ch(blue_i);
    sec2_r <= sec2_nxt;
    d2_r   <= mx2 - mn2;
    p2_r   <= p2_nxt;
    q2_r   <= q2_nxt;
    a3_r   <= (d2_r == '0);
    num3_r <= num3_nxt;
    six3_r <= six3_nxt;
    // full turn wraps to zero; achromatic gets divisor one so the quotient is zero
    num4_r <= (num3_r >= six3_r) ? '0 : num3_r;
    den4_r <= a3_r ? NW'(1) : six3_r;
  end

  assign ctl_o = ctl4_r;
  assign num_o = num4_r;
  assign den_o = den4_r;

endmodule

// ----- design/rph_div_stage.sv -----
// rph_div_stage: one registered restoring division step, one quotient bit
// depends on rph_pkg

module rph_div_stage #(
  parameter int NW = rph_pkg::SAMPLE_BITS_DEF + 2,
  parameter int QW = rph_pkg::HUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rph_pkg::rph_ctl_t ctl_i,
  input  logic [NW-1:0]     rem_i,
  input  logic [NW-1:0]     den_i,
  input  logic [QW-1:0]     quo_i,
  output rph_pkg::rph_ctl_t ctl_o,
  output logic [NW-1:0]     rem_o,
  output logic [NW-1:0]     den_o,
  output logic [QW-1:0]     quo_o
);
  import rph_pkg::*;

  rph_ctl_t      ctl_r;
  logic [NW-1:0] rem_r, den_r;
  logic [QW-1:0] quo_r;

  logic [NW:0]   rem2, den_ext, diff;
  logic          ge;

  always_comb begin
    rem2    = {rem_i, 1'b0};
    den_ext = {1'b0, den_i};
    diff    = rem2 - den_ext;
    ge      = (rem2 >= den_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= ge ? diff[NW-1:0] : rem2[NW-1:0];
    den_r <= den_i;
    quo_r <= {quo_i[QW-2:0], ge};
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign quo_o = quo_r;

endmodule
